// ===== sv/wip_pkg.sv =====
`default_nettype none
package wip_pkg;

  localparam int unsigned MaxSources = 16;
  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned SlotW      = $clog2(MaxSources);
  localparam int unsigned CntW       = $clog2(MaxSources + 1);
  localparam int unsigned FwW        = $clog2(MaxWidth + 1);

  localparam logic [0:0] OP_LOAD  = 1'b0;
  localparam logic [0:0] OP_PIXEL = 1'b1;

  localparam logic [0:0] CFG_SOURCE_COUNT = 1'b0;
  localparam logic [0:0] CFG_FRAME_WIDTH  = 1'b1;

  localparam logic signed [33:0] SIN_C9 = 34'sd172272;

  typedef struct packed {
    logic [0:0]  op;
    logic [3:0]  source_slot;
    logic [11:0] coord_x;
    logic [11:0] coord_y;
    logic [15:0] fade_radius;
    logic [15:0] wave_length;
    logic [7:0]  amp_red;
    logic [7:0]  amp_green;
    logic [7:0]  amp_blue;
  } in_item_t;

  typedef struct packed {
    logic [23:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_IDX, ST_SRC, ST_SQX, ST_SQY, ST_ROOT, ST_CMP, ST_FADE,
    ST_MOD, ST_PHASE, ST_X2, ST_POLY, ST_SIN, ST_TW, ST_TF, ST_OUT
  } state_e;

  // Horner coefficients after the x^9 one, Q30
  function automatic logic signed [33:0] sin_coef(input logic [1:0] k);
    logic signed [33:0] c;
    case (k)
      2'd0:    c = -34'sd5026995;
      2'd1:    c = 34'sd85569306;
      2'd2:    c = -34'sd693598668;
      2'd3:    c = 34'sd1686629713;
      default: c = 34'sd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/wip_in_if.sv =====
`default_nettype none
interface wip_in_if;
  logic               valid;
  logic               ready;
  wip_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/wip_out_if.sv =====
`default_nettype none
interface wip_out_if;
  logic               valid;
  logic               ready;
  wip_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/wave_interference_pixel.sv =====
`default_nettype none
// channel   dir  payload
// in_if     in   op, source_slot, coord_x/y, fade_radius, wave_length, amps
// out_if    out  pixel_index, red, green, blue
// cfg       in   cfg_we_i / cfg_idx_i / cfg_data_i, write only
// A load item writes the source table while idle; the table is undefined
// until loaded. A pixel item takes, per active source, a 21-step root,
// 16+21+16 divider steps and 14 passes through the one shared multiplier;
// a source with zero radius or wavelength is skipped before the root, and
// one out of range after it. Reset clears control and the source count and
// sets the frame width to 640. The result waits in an output register; a
// stalled output holds the engine only when the next result is ready.
module wave_interference_pixel (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [0:0]          cfg_idx_i,
  input  wire  [12:0]         cfg_data_i,
  wip_in_if.sink              in_if,
  wip_out_if.source           out_if
);
  import wip_pkg::*;

  state_e state_q, state_d;
  logic   ph_q;

  logic [CntW-1:0]  count_q;
  logic [FwW-1:0]   fw_q;

  logic [23:0] pos_mem [MaxSources];
  logic [31:0] shape_mem [MaxSources];
  logic [23:0] col_mem [MaxSources];
  logic [23:0] rd_pos_q, rd_col_q;
  logic [31:0] rd_shape_q;

  logic [11:0] px_q, py_q;
  logic [CntW-1:0] idx_q;
  logic [23:0] pix_idx_q;
  logic [4:0]  cnt_q;
  logic [1:0]  ch_q;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_q;
  logic signed [37:0] prod_tr;

  logic [24:0] sq_q;
  logic [41:0] v_q, res_q, bit_q;
  logic [42:0] rb_sum;
  logic [20:0] d8_q;

  logic [23:0] rem_q, den_q;
  logic [20:0] num_q;
  logic [16:0] quo_q;
  logic [24:0] dv_t;
  logic        dv_ge;
  logic [23:0] rem_d;
  logic [16:0] quo_d;

  logic [16:0] fade_q;
  logic [1:0]  quad_q;
  logic [30:0] x_q;
  logic [30:0] x2_q;
  logic signed [33:0] p_q;
  logic [17:0] w_q;
  logic [25:0] t_q;
  logic [47:0] acc_q [3];

  logic [11:0] dx, dy, sx, sy;
  logic [23:0] rq, lq;
  logic [7:0]  amp;
  logic [15:0] ph_frac;
  logic [14:0] r_fold;
  logic signed [37:0] s_full;
  logic [30:0] s_cl;
  logic        in_acc;

  out_item_t out_q;
  logic      out_valid_q;

  assign sx = rd_pos_q[23:12];
  assign sy = rd_pos_q[11:0];
  assign dx = (sx > px_q) ? sx - px_q : px_q - sx;
  assign dy = (sy > py_q) ? sy - py_q : py_q - sy;
  assign rq = {rd_shape_q[31:16], 8'd0};
  assign lq = {rd_shape_q[15:0], 8'd0};
  assign rb_sum = {1'b0, res_q} + {1'b0, bit_q};

  // shared restoring divider step
  assign dv_t  = {rem_q, num_q[20]};
  assign dv_ge = dv_t >= {1'b0, den_q};
  assign rem_d = dv_ge ? 24'(dv_t - {1'b0, den_q}) : dv_t[23:0];
  assign quo_d = {quo_q[15:0], dv_ge};

  assign ph_frac = quo_d[15:0];
  assign r_fold  = ph_frac[14] ? 15'(15'd16384 - {1'b0, ph_frac[13:0]})
                               : {1'b0, ph_frac[13:0]};

  // truncation toward zero of a Q30 product
  assign prod_tr = prod_q[67] ? 38'((prod_q + 68'sd1073741823) >>> 30)
                              : 38'(prod_q >>> 30);
  assign s_full  = prod_tr;
  assign s_cl    = (s_full < 0) ? 31'd0 :
                   (s_full > 38'sd1073741824) ? 31'd1073741824 : s_full[30:0];

  assign in_acc = in_if.valid && in_if.ready;

  always_comb begin
    case (ch_q)
      2'd0:    amp = rd_col_q[23:16];
      2'd1:    amp = rd_col_q[15:8];
      default: amp = rd_col_q[7:0];
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_if.ready = (state_q == ST_IDLE);
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_IDX:  begin mul_a = {22'd0, py_q}; mul_b = {21'd0, fw_q}; end
      ST_SQX:  begin mul_a = {22'd0, dx}; mul_b = {22'd0, dx}; end
      ST_SQY:  begin mul_a = {22'd0, dy}; mul_b = {22'd0, dy}; end
      ST_X2:   begin mul_a = {3'd0, x_q}; mul_b = {3'd0, x_q}; end
      ST_POLY: begin mul_a = p_q; mul_b = {3'd0, x2_q}; end
      ST_SIN:  begin mul_a = p_q; mul_b = {3'd0, x_q}; end
      ST_TW:   begin mul_a = {16'd0, w_q}; mul_b = {26'd0, amp}; end
      ST_TF:   begin mul_a = {8'd0, t_q}; mul_b = {17'd0, fade_q}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc && in_if.data.op == OP_PIXEL) state_d = ST_IDX;
      ST_IDX:   if (ph_q) state_d = ST_SRC;
      ST_SRC: begin
        if (!ph_q && idx_q >= count_q) state_d = ST_OUT;
        else if (ph_q && rq != '0 && lq != '0) state_d = ST_SQX;
      end
      ST_SQX:   if (ph_q) state_d = ST_SQY;
      ST_SQY:   if (ph_q) state_d = ST_ROOT;
      ST_ROOT:  if (cnt_q == 5'd20) state_d = ST_CMP;
      ST_CMP: begin
        if ({3'd0, d8_q} >= rq) state_d = ST_SRC;
        else if (d8_q == '0) state_d = ST_MOD;
        else state_d = ST_FADE;
      end
      ST_FADE:  if (cnt_q == 5'd15) state_d = ST_MOD;
      ST_MOD:   if (cnt_q == 5'd20) state_d = ST_PHASE;
      ST_PHASE: if (cnt_q == 5'd15) state_d = ST_X2;
      ST_X2:    if (ph_q) state_d = ST_POLY;
      ST_POLY:  if (ph_q && cnt_q == 5'd3) state_d = ST_SIN;
      ST_SIN:   if (ph_q) state_d = ST_TW;
      ST_TW:    if (ph_q) state_d = ST_TF;
      ST_TF:    if (ph_q) state_d = (ch_q == 2'd2) ? ST_SRC : ST_TW;
      ST_OUT:   if (!out_valid_q || out_if.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= 1'b0;
      count_q     <= '0;
      fw_q        <= FwW'(640);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDX, ST_SRC, ST_SQX, ST_SQY, ST_X2, ST_POLY, ST_SIN, ST_TW, ST_TF:
          ph_q <= (state_d == state_q) ? ~ph_q : 1'b0;
        default: ph_q <= 1'b0;
      endcase
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SOURCE_COUNT: count_q <= (cfg_data_i[4:0] > 5'(MaxSources))
                                       ? CntW'(MaxSources) : CntW'(cfg_data_i[4:0]);
          CFG_FRAME_WIDTH:  fw_q <= (cfg_data_i > 13'(MaxWidth))
                                    ? FwW'(MaxWidth) : FwW'(cfg_data_i);
          default: ;
        endcase
      end
      if (state_q == ST_OUT && (!out_valid_q || out_if.ready)) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (state_q == ST_IDLE && in_acc) begin
      if (in_if.data.op == OP_LOAD) begin
        pos_mem[in_if.data.source_slot[SlotW-1:0]] <=
          {in_if.data.coord_x, in_if.data.coord_y};
        shape_mem[in_if.data.source_slot[SlotW-1:0]] <=
          {in_if.data.fade_radius, in_if.data.wave_length};
        col_mem[in_if.data.source_slot[SlotW-1:0]] <=
          {in_if.data.amp_red, in_if.data.amp_green, in_if.data.amp_blue};
      end
    end
    rd_pos_q   <= pos_mem[idx_q[SlotW-1:0]];
    rd_shape_q <= shape_mem[idx_q[SlotW-1:0]];
    rd_col_q   <= col_mem[idx_q[SlotW-1:0]];

    case (state_q)
      ST_IDLE: begin
        px_q <= in_if.data.coord_x;
        py_q <= in_if.data.coord_y;
        idx_q <= '0;
        for (int c = 0; c < 3; c++) acc_q[c] <= '0;
      end
      ST_IDX: if (ph_q) pix_idx_q <= 24'(prod_q[24:0] + 25'(px_q));
      ST_SRC: if (ph_q && (rq == '0 || lq == '0)) idx_q <= idx_q + 1'b1;
      ST_SQX: if (ph_q) sq_q <= prod_q[24:0];
      ST_SQY: if (ph_q) begin
        v_q   <= {1'b0, sq_q + prod_q[24:0], 16'd0};
        res_q <= '0;
        bit_q <= 42'd1 << 40;
        cnt_q <= '0;
      end
      ST_ROOT: begin
        if ({1'b0, v_q} >= rb_sum) begin
          v_q   <= 42'({1'b0, v_q} - rb_sum);
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd20) d8_q <= ({1'b0, v_q} >= rb_sum)
                                    ? 21'((res_q >> 1) + bit_q) : 21'(res_q >> 1);
      end
      ST_CMP: begin
        cnt_q <= '0;
        if ({3'd0, d8_q} >= rq) begin
          idx_q <= idx_q + 1'b1;
        end else if (d8_q == '0) begin
          fade_q <= 17'd65536;
          rem_q <= '0; den_q <= lq; num_q <= d8_q;
        end else begin
          rem_q <= rq - {3'd0, d8_q}; den_q <= rq; num_q <= '0;
        end
      end
      ST_FADE: begin
        quo_q <= quo_d;
        if (cnt_q == 5'd15) begin
          fade_q <= {1'b0, quo_d[15:0]};
          rem_q <= '0; den_q <= lq; num_q <= d8_q; cnt_q <= '0;
        end else begin
          rem_q <= rem_d; num_q <= num_q << 1;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      ST_MOD: begin
        rem_q <= rem_d;
        if (cnt_q == 5'd20) begin
          num_q <= '0; cnt_q <= '0;
        end else begin
          num_q <= num_q << 1;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      ST_PHASE: begin
        rem_q <= rem_d; quo_q <= quo_d; num_q <= num_q << 1;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd15) begin
          quad_q <= ph_frac[15:14];
          x_q    <= {r_fold, 16'd0};
        end
      end
      ST_X2: if (ph_q) begin
        x2_q  <= prod_tr[30:0];
        p_q   <= SIN_C9;
        cnt_q <= '0;
      end
      ST_POLY: if (ph_q) begin
        p_q   <= sin_coef(cnt_q[1:0]) + prod_tr[33:0];
        cnt_q <= cnt_q + 1'b1;
      end
      ST_SIN: if (ph_q) begin
        w_q  <= quad_q[1] ? 18'((32'd1073741824 - {1'b0, s_cl}) >> 14)
                          : 18'((32'd1073741824 + {1'b0, s_cl}) >> 14);
        ch_q <= '0;
      end
      ST_TW: if (ph_q) t_q <= prod_q[25:0];
      ST_TF: if (ph_q) begin
        acc_q[ch_q] <= acc_q[ch_q] + prod_q[47:0];
        if (ch_q == 2'd2) idx_q <= idx_q + 1'b1;
        else ch_q <= ch_q + 1'b1;
      end
      ST_OUT: if (!out_valid_q || out_if.ready) begin
        out_q.pixel_index <= pix_idx_q;
        out_q.red   <= (acc_q[0][47:32] > 16'd255) ? 8'd255 : acc_q[0][39:32];
        out_q.green <= (acc_q[1][47:32] > 16'd255) ? 8'd255 : acc_q[1][39:32];
        out_q.blue  <= (acc_q[2][47:32] > 16'd255) ? 8'd255 : acc_q[2][39:32];
      end
      default: ;
    endcase
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

endmodule
`default_nettype wire
